[hw/rtl/gids_pkg.sv]
package gids_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] RegEnabled        = 3'd0;
  localparam logic [2:0] RegPowerGated     = 3'd1;
  localparam logic [2:0] RegActiveLow      = 3'd2;
  localparam logic [2:0] RegSampleInterval = 3'd3;
  localparam logic [2:0] RegSettlingTime   = 3'd4;
  localparam logic [2:0] RegDebounce       = 3'd5;

  localparam int CfgAddrWidth = 5;
  localparam int InDataWidth  = 72;
  localparam int OutDataWidth = 72;

  // configuration bundle from the register file to the poll logic
  typedef struct packed {
    logic        enabled;
    logic        power_gated;
    logic        invert_pin;
    logic [31:0] sample_gap;
    logic [31:0] settle_time;
    logic [31:0] hold_time;
  } cfg_t;

  // one poll item
  typedef struct packed {
    logic [31:0] power_on_time;
    logic        pin_level;
    logic [31:0] now_ms;
  } poll_t;

  // one result item
  typedef struct packed {
    logic        power_release;
    logic        power_request;
    logic        sample_ready;
    logic [31:0] last_change_ms;
    logic [31:0] changes_seen;
    logic        active_level;
    logic        busy_status;
  } result_t;

endpackage

[hw/rtl/gated_input_debounce_sampler_unit.sv]
// Switch input debounce with power-gated sampling. Each poll beat on the
// slave stream gives one result beat on the master stream, in order. A poll
// is registered on entry, then worked out against the block state and
// written to the result register once that register is free or being
// drained; one poll is taken every cycle while the master side keeps
// taking results. Configuration goes through the APB port at byte address
// 4*index and must only be written while no poll is in flight.
module gated_input_debounce_sampler_unit
  import gids_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  // slave stream
  input  logic                    s_tvalid,
  output logic                    s_tready,
  // now_ms[31:0], pin_level[32], power_on_time[64:33], zero pad
  input  logic [InDataWidth-1:0]  s_tdata,
  // master stream
  output logic                    m_tvalid,
  input  logic                    m_tready,
  // busy_status[0], active_level[1], changes_seen[33:2],
  // last_change_ms[65:34], sample_ready[66], power_request[67],
  // power_release[68], zero pad
  output logic [OutDataWidth-1:0] m_tdata,
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);

  localparam int PollBits   = $bits(poll_t);
  localparam int ResultBits = $bits(result_t);

  cfg_t    cfg;
  poll_t   poll;
  logic    poll_valid;
  logic    advance;
  result_t result;
  result_t result_q;

  gids_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // a poll moves on when the result register is free or being drained
  assign advance  = poll_valid && (!m_tvalid || m_tready);
  assign s_tready = !poll_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      poll_valid <= 1'b0;
    end else if (s_tready) begin
      poll_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      poll <= poll_t'(s_tdata[PollBits-1:0]);
    end
  end

  gids_core u_core (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .advance (advance),
    .poll    (poll),
    .result  (result)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_q <= result;
    end
  end

  assign m_tdata = {{(OutDataWidth-ResultBits){1'b0}}, result_q};

endmodule

[hw/rtl/gids_cfg.sv]
module gids_cfg
  import gids_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrWidth-1:0] paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  output cfg_t                    cfg
);

  logic [2:0] reg_index;
  logic       wr_en;

  assign reg_index = paddr[CfgAddrWidth-1:2];
  assign wr_en     = psel && penable && pwrite;
  assign pready    = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      case (reg_index)
        RegEnabled:        cfg.enabled     <= pwdata[0];
        RegPowerGated:     cfg.power_gated <= pwdata[0];
        RegActiveLow:      cfg.invert_pin  <= pwdata[0];
        RegSampleInterval: cfg.sample_gap  <= pwdata;
        RegSettlingTime:   cfg.settle_time <= pwdata;
        RegDebounce:       cfg.hold_time   <= pwdata;
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (reg_index)
      RegEnabled:        prdata = {31'd0, cfg.enabled};
      RegPowerGated:     prdata = {31'd0, cfg.power_gated};
      RegActiveLow:      prdata = {31'd0, cfg.invert_pin};
      RegSampleInterval: prdata = cfg.sample_gap;
      RegSettlingTime:   prdata = cfg.settle_time;
      RegDebounce:       prdata = cfg.hold_time;
      default:           prdata = '0;
    endcase
  end

endmodule

[hw/rtl/gids_core.sv]
module gids_core
  import gids_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    advance,
  input  poll_t   poll,
  output result_t result
);

  // poll state
  logic        gate_settling, gate_settling_next;
  logic [31:0] last_sample_ms, last_sample_ms_next;
  logic [31:0] stable_since_ms, stable_since_ms_next;
  logic        timing_change, timing_change_next;
  logic        candidate_level, candidate_level_next;
  logic        committed_level, committed_level_next;
  logic        have_sample, have_sample_next;
  logic [31:0] change_total, change_total_next;
  logic [31:0] change_stamp, change_stamp_next;

  logic        logical;
  logic [31:0] since_sample;
  logic [31:0] since_power;
  logic [31:0] since_stable;
  logic        interval_wait;
  logic        settle_wait;
  logic        new_candidate;
  logic        commit_en;
  logic        commit_lvl;
  logic        busy, preq, prel;

  assign logical      = poll.pin_level ^ cfg.invert_pin;
  assign since_sample = poll.now_ms - last_sample_ms;
  assign since_power  = poll.now_ms - poll.power_on_time;
  assign since_stable = poll.now_ms - stable_since_ms;

  assign interval_wait = have_sample && (cfg.sample_gap != '0) &&
                         (since_sample < cfg.sample_gap);
  assign settle_wait   = (cfg.settle_time != '0) &&
                         (since_power < cfg.settle_time);
  assign new_candidate = (logical != candidate_level) || !timing_change;

  // step logic for one poll
  always_comb begin
    gate_settling_next   = gate_settling;
    last_sample_ms_next  = last_sample_ms;
    stable_since_ms_next = stable_since_ms;
    timing_change_next   = timing_change;
    candidate_level_next = candidate_level;
    have_sample_next     = have_sample;
    busy       = 1'b0;
    preq       = 1'b0;
    prel       = 1'b0;
    commit_en  = 1'b0;
    commit_lvl = logical;
    if (cfg.enabled) begin
      if (cfg.power_gated) begin
        busy = 1'b1;
        if (gate_settling || !interval_wait) begin
          preq               = !gate_settling;
          gate_settling_next = 1'b1;
          if (!settle_wait) begin
            commit_en           = 1'b1;
            have_sample_next    = 1'b1;
            last_sample_ms_next = poll.now_ms;
            prel                = 1'b1;
            gate_settling_next  = 1'b0;
          end
        end
      end else if (cfg.hold_time == '0) begin
        commit_en = 1'b1;
      end else if (new_candidate) begin
        // restart the stable period; a nonzero debounce never passes at once
        candidate_level_next = logical;
        stable_since_ms_next = poll.now_ms;
        timing_change_next   = 1'b1;
      end else if (since_stable >= cfg.hold_time) begin
        commit_en          = 1'b1;
        commit_lvl         = candidate_level;
        timing_change_next = 1'b0;
      end
    end
  end

  // commit a level change
  always_comb begin
    committed_level_next = committed_level;
    change_total_next    = change_total;
    change_stamp_next    = change_stamp;
    if (commit_en && (commit_lvl != committed_level)) begin
      committed_level_next = commit_lvl;
      change_total_next    = change_total + 32'd1;
      change_stamp_next    = poll.now_ms;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gate_settling   <= 1'b0;
      last_sample_ms  <= '0;
      stable_since_ms <= '0;
      timing_change   <= 1'b0;
      candidate_level <= 1'b0;
      committed_level <= 1'b0;
      have_sample     <= 1'b0;
      change_total    <= '0;
      change_stamp    <= '0;
    end else if (advance) begin
      gate_settling   <= gate_settling_next;
      last_sample_ms  <= last_sample_ms_next;
      stable_since_ms <= stable_since_ms_next;
      timing_change   <= timing_change_next;
      candidate_level <= candidate_level_next;
      committed_level <= committed_level_next;
      have_sample     <= have_sample_next;
      change_total    <= change_total_next;
      change_stamp    <= change_stamp_next;
    end
  end

  // result of this poll
  always_comb begin
    result.busy_status    = busy;
    result.active_level   = committed_level_next;
    result.changes_seen   = change_total_next;
    result.last_change_ms = change_stamp_next;
    result.sample_ready   = have_sample_next;
    result.power_request  = preq;
    result.power_release  = prel;
  end

endmodule

[sim/tb_gated_input_debounce_sampler_unit.sv]
module tb_gated_input_debounce_sampler_unit;
  import gids_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int StallLimit = 2000;
  localparam int RandomPhases = 10;
  localparam int ItemsPerPhase = 75;

  typedef enum logic [1:0] {
    PhIdle     = 2'd0,
    PhSettling = 2'd1
  } gate_phase_t;

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    s_tvalid = 1'b0;
  logic                    s_tready;
  // now_ms[31:0], pin_level[32], power_on_time[64:33], zero pad
  logic [InDataWidth-1:0]  s_tdata = '0;
  logic                    m_tvalid;
  logic                    m_tready = 1'b0;
  // busy_status[0], active_level[1], changes_seen[33:2],
  // last_change_ms[65:34], sample_ready[66], power_request[67],
  // power_release[68], zero pad
  logic [OutDataWidth-1:0] m_tdata;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [CfgAddrWidth-1:0] paddr = '0;
  logic [31:0]             pwdata = '0;
  logic [31:0]             prdata;
  logic                    pready;

  gated_input_debounce_sampler_unit u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #5 clk = ~clk;

  // polls waiting to be driven and results waiting to be seen
  poll_t   pending_polls[$];
  result_t expected_results[$];
  int      polls_queued = 0;
  int      results_seen = 0;
  int      err_count = 0;
  int      send_idle_pct = 18;
  int      recv_idle_pct = 70;
  int      stall_cycles = 0;

  // mirror of the configuration registers
  cfg_t        sampler_cfg = '0;

  // mirror of the sampler state
  gate_phase_t gate_phase = PhIdle;
  logic [31:0] last_sample_ms = '0;
  logic [31:0] stable_since_ms = '0;
  logic        timing_change = 1'b0;
  logic        candidate_level = 1'b0;
  logic        committed_level = 1'b0;
  logic        have_sample = 1'b0;
  logic [31:0] change_total = '0;
  logic [31:0] change_stamp = '0;

  // stimulus time base and pin, kept across phases
  logic [31:0] ms_now = 32'hFFFF_FF80;
  logic        pin_now = 1'b0;

  function automatic void commit_level(input logic lvl, input logic [31:0] now);
    if (lvl != committed_level) begin
      committed_level = lvl;
      change_stamp = now;
      change_total = change_total + 32'd1;
    end
  endfunction

  // next result of the sampler for one accepted poll
  function automatic result_t predict_poll_result(input poll_t p);
    result_t     r;
    logic        lvl;
    logic        hold_interval;
    logic [31:0] dt;
    r = '0;
    lvl = p.pin_level ^ sampler_cfg.invert_pin;
    if (sampler_cfg.enabled) begin
      if (sampler_cfg.power_gated) begin
        r.busy_status = 1'b1;
        hold_interval = 1'b0;
        // idle: wait out the sample interval, then ask for power
        if (gate_phase != PhSettling) begin
          dt = p.now_ms - last_sample_ms;
          if (have_sample && sampler_cfg.sample_gap != 0 &&
              dt < sampler_cfg.sample_gap) begin
            hold_interval = 1'b1;
          end else begin
            r.power_request = 1'b1;
            gate_phase = PhSettling;
          end
        end
        // settling done: read and drop power
        dt = p.now_ms - p.power_on_time;
        if (!hold_interval &&
            (sampler_cfg.settle_time == 0 || dt >= sampler_cfg.settle_time)) begin
          commit_level(lvl, p.now_ms);
          have_sample = 1'b1;
          last_sample_ms = p.now_ms;
          r.power_release = 1'b1;
          gate_phase = PhIdle;
        end
      end else if (sampler_cfg.hold_time == 0) begin
        commit_level(lvl, p.now_ms);
      end else begin
        // restart the stable period on a new level or when nothing is pending
        if (lvl != candidate_level || !timing_change) begin
          candidate_level = lvl;
          stable_since_ms = p.now_ms;
          timing_change = 1'b1;
        end
        dt = p.now_ms - stable_since_ms;
        if (dt >= sampler_cfg.hold_time) begin
          commit_level(candidate_level, p.now_ms);
          timing_change = 1'b0;
        end
      end
    end
    r.active_level = committed_level;
    r.changes_seen = change_total;
    r.last_change_ms = change_stamp;
    r.sample_ready = have_sample;
    return r;
  endfunction

  // poll driver
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(
          predict_poll_result(poll_t'(s_tdata[$bits(poll_t)-1:0])));
      end
      if (!s_tvalid || s_tready) begin
        if (pending_polls.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          s_tdata <= InDataWidth'(pending_polls.pop_front());
          s_tvalid <= 1'b1;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      $display("%0t %s mismatch: expected %0h actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  // result monitor
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = result_t'(m_tdata[$bits(result_t)-1:0]);
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result beat: expected none actual %0h", $time, got);
        err_count++;
      end else begin
        want = expected_results.pop_front();
        check_field("busy_status", 32'(want.busy_status), 32'(got.busy_status));
        check_field("active_level", 32'(want.active_level), 32'(got.active_level));
        check_field("changes_seen", want.changes_seen, got.changes_seen);
        check_field("last_change_ms", want.last_change_ms, got.last_change_ms);
        check_field("sample_ready", 32'(want.sample_ready), 32'(got.sample_ready));
        check_field("power_request", 32'(want.power_request), 32'(got.power_request));
        check_field("power_release", 32'(want.power_release), 32'(got.power_release));
      end
    end
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // watchdog on cycles with no beat on any port
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= StallLimit) begin
      $display("[gated_input_debounce_sampler_unit] ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegEnabled:        sampler_cfg.enabled = val[0];
      RegPowerGated:     sampler_cfg.power_gated = val[0];
      RegActiveLow:      sampler_cfg.invert_pin = val[0];
      RegSampleInterval: sampler_cfg.sample_gap = val;
      RegSettlingTime:   sampler_cfg.settle_time = val;
      RegDebounce:       sampler_cfg.hold_time = val;
      default: ;
    endcase
  endtask

  task automatic wait_all_results();
    while (results_seen != polls_queued) @(posedge clk);
  endtask

  // write every register once the block has gone quiet
  task automatic configure_unit(input logic en, gated, alow,
                                input logic [31:0] interval, settle, deb);
    wait_all_results();
    repeat (4) @(posedge clk);
    reg_write(RegEnabled, {31'd0, en});
    reg_write(RegPowerGated, {31'd0, gated});
    reg_write(RegActiveLow, {31'd0, alow});
    reg_write(RegSampleInterval, interval);
    reg_write(RegSettlingTime, settle);
    reg_write(RegDebounce, deb);
  endtask

  task automatic push_poll(input logic [31:0] now, input logic pin,
                           input logic [31:0] pon);
    poll_t p;
    p.now_ms = now;
    p.pin_level = pin;
    p.power_on_time = pon;
    pending_polls.push_back(p);
    polls_queued++;
  endtask

  // mostly short times, sometimes zero, full scale or anything
  function automatic logic [31:0] pick_ms();
    case ($urandom_range(0, 9))
      0:       return 32'd0;
      1:       return 32'hFFFF_FFFF;
      2:       return $urandom;
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  // a poll from a slowly advancing clock with a bouncing pin
  task automatic push_random_poll();
    logic [31:0] now;
    logic [31:0] pon;
    int          sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) ms_now = ms_now + $urandom;
    else ms_now = ms_now + $urandom_range(0, 8);
    now = (sel >= 5 && sel < 8) ? $urandom : ms_now;
    if ($urandom_range(0, 3) == 0) pin_now = ~pin_now;
    sel = $urandom_range(0, 9);
    if (sel < 6) pon = now - $urandom_range(0, 24);
    else if (sel < 8) pon = now + $urandom_range(1, 8);
    else pon = $urandom;
    push_poll(now, pin_now, pon);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // disabled after reset: nothing moves
    push_poll(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    push_poll(32'd0, 1'b0, 32'd0);

    // always-on with no debounce, both polarities
    configure_unit(1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd0);
    push_poll(32'd10, 1'b1, 32'd0);
    push_poll(32'd11, 1'b0, 32'd0);
    push_poll(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
    configure_unit(1'b1, 1'b0, 1'b1, 32'd0, 32'd0, 32'd0);
    push_poll(32'd20, 1'b1, 32'd0);
    push_poll(32'd21, 1'b0, 32'd0);

    // debounce with a bounce in the middle
    configure_unit(1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'd5);
    push_poll(32'd100, 1'b1, 32'd0);
    push_poll(32'd103, 1'b1, 32'd0);
    push_poll(32'd105, 1'b1, 32'd0);
    push_poll(32'd106, 1'b0, 32'd0);
    push_poll(32'd108, 1'b1, 32'd0);
    push_poll(32'd111, 1'b0, 32'd0);

    // gated: settle wait, read, interval wait, then a new request that waits to settle
    configure_unit(1'b1, 1'b1, 1'b0, 32'd10, 32'd3, 32'd0);
    push_poll(32'd200, 1'b1, 32'd199);
    push_poll(32'd202, 1'b1, 32'd199);
    push_poll(32'd205, 1'b0, 32'd199);
    push_poll(32'd212, 1'b0, 32'd211);

    // mode switched while settling, then resumed
    configure_unit(1'b1, 1'b1, 1'b0, 32'd10, 32'd50, 32'd0);
    push_poll(32'd1000, 1'b1, 32'd990);
    configure_unit(1'b1, 1'b0, 1'b0, 32'd10, 32'd50, 32'd0);
    push_poll(32'd1001, 1'b1, 32'd990);
    configure_unit(1'b1, 1'b1, 1'b0, 32'd10, 32'd50, 32'd0);
    push_poll(32'd1100, 1'b0, 32'd1000);

    // full-scale interval and debounce, wrapping differences
    configure_unit(1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    push_poll(32'd5, 1'b0, 32'd0);
    push_poll(32'd1099, 1'b0, 32'd0);
    configure_unit(1'b1, 1'b0, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF);
    push_poll(32'd0, 1'b1, 32'd0);
    push_poll(32'hFFFF_FFFF, 1'b1, 32'd0);

    // disabled in gated mode
    configure_unit(1'b0, 1'b1, 1'b1, 32'd0, 32'd0, 32'd0);
    push_poll(32'd300, 1'b1, 32'd0);

    // random phases, each under a fresh setting
    for (int ph = 0; ph < RandomPhases; ph++) begin
      configure_unit($urandom_range(0, 9) != 0, 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), pick_ms(), pick_ms(), pick_ms());
      if (ph == 4) begin
        send_idle_pct = 70;
        recv_idle_pct = 18;
      end else if (ph == 7) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < ItemsPerPhase; i++) begin
        // sender holds off until every result is back
        if (ph == 5 && i == ItemsPerPhase / 2) wait_all_results();
        push_random_poll();
      end
    end

    wait_all_results();
    repeat (6) @(posedge clk);
    if (err_count == 0 && expected_results.size() == 0) begin
      $display("[gated_input_debounce_sampler_unit] OK");
    end else begin
      $display("[gated_input_debounce_sampler_unit] ERROR");
    end
    $finish;
  end

endmodule
